/* rtl/core/kte_pkg.sv */
package kte_pkg;

    localparam int IN_DATA_W  = 200;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 80;
    localparam int KEY_W      = 64;
    localparam int PAY_W      = 64;
    localparam int USED_W     = 7;

    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0,
        OP_ADD    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_MOVE   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_REFUSED   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_RM_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    scan_start;
        logic    shift_start;
        logic    wr_add_new;
        logic    wr_upd_pay;
        logic    wr_move_key;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cnt_clr;
        logic    dirty_set;
        logic    dirty_clr;
        logic    resp_load;
        t_status resp_status;
        logic    resp_found;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic upd;
        logic hit_key;
        logic hit_new;
        logic keys_eq;
        logic full;
        logic scan_done;
        logic shift_done;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/core/kte_ctrl.sv */
module kte_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [2:0]        i_in_op,
    output logic              o_in_ready,
    input  kte_pkg::t_dp_sts  i_sts,
    output kte_pkg::t_dp_cmd  o_cmd
);

    kte_pkg::t_state r_state;
    kte_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kte_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.resp_status = kte_pkg::ST_DONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            kte_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_in_op) inside
                        kte_pkg::OP_LOOKUP, kte_pkg::OP_ADD,
                        kte_pkg::OP_REMOVE, kte_pkg::OP_MOVE: begin
                            o_cmd.scan_start = 1'b1;
                            n_state = kte_pkg::S_SCAN;
                        end
                        default: begin
                            n_state = kte_pkg::S_DECIDE;
                        end
                    endcase
                end
            end
            kte_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = kte_pkg::S_DECIDE;
                end
            end
            kte_pkg::S_DECIDE: begin
                if (i_sts.op == kte_pkg::OP_REMOVE && i_sts.hit_key) begin
                    o_cmd.shift_start = 1'b1;
                    n_state = kte_pkg::S_SHIFT;
                end else if (i_sts.out_free) begin
                    o_cmd.resp_load = 1'b1;
                    n_state = kte_pkg::S_IDLE;
                    case (i_sts.op)
                        kte_pkg::OP_LOOKUP: begin
                            if (i_sts.hit_key) begin
                                o_cmd.resp_found = 1'b1;
                            end else begin
                                o_cmd.resp_status = kte_pkg::ST_NOT_FOUND;
                            end
                        end
                        kte_pkg::OP_ADD: begin
                            if (i_sts.hit_key) begin
                                if (i_sts.upd) begin
                                    o_cmd.wr_upd_pay = 1'b1;
                                    o_cmd.dirty_set  = 1'b1;
                                end else begin
                                    o_cmd.resp_status = kte_pkg::ST_EXISTS;
                                end
                            end else if (i_sts.full) begin
                                o_cmd.resp_status = kte_pkg::ST_FULL;
                            end else begin
                                o_cmd.wr_add_new = 1'b1;
                                o_cmd.cnt_inc    = 1'b1;
                                o_cmd.dirty_set  = 1'b1;
                            end
                        end
                        kte_pkg::OP_REMOVE: begin
                            o_cmd.resp_status = kte_pkg::ST_NOT_FOUND;
                        end
                        kte_pkg::OP_MOVE: begin
                            if (i_sts.keys_eq || i_sts.hit_new) begin
                                o_cmd.resp_status = kte_pkg::ST_REFUSED;
                            end else if (!i_sts.hit_key) begin
                                o_cmd.resp_status = kte_pkg::ST_NOT_FOUND;
                            end else begin
                                o_cmd.wr_move_key = 1'b1;
                                o_cmd.dirty_set   = 1'b1;
                            end
                        end
                        kte_pkg::OP_CLEAR: begin
                            o_cmd.cnt_clr   = 1'b1;
                            o_cmd.dirty_clr = 1'b1;
                        end
                        default: begin
                            o_cmd.resp_status = kte_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            kte_pkg::S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = kte_pkg::S_RM_DONE;
                end
            end
            kte_pkg::S_RM_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.resp_load = 1'b1;
                    o_cmd.cnt_dec   = 1'b1;
                    o_cmd.dirty_set = 1'b1;
                    n_state = kte_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kte_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/kte_datapath.sv */
module kte_datapath #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [kte_pkg::IN_DATA_W-1:0]   i_in_data,
    input  logic [kte_pkg::IN_USER_W-1:0]   i_in_user,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [kte_pkg::OUT_DATA_W-1:0]  o_out_data,
    input  kte_pkg::t_dp_cmd                i_cmd,
    output kte_pkg::t_dp_sts                o_sts
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] CntMax = CW'(MAX_ENTRIES);

    logic [kte_pkg::KEY_W-1:0] r_key_mem [MAX_ENTRIES];
    logic [kte_pkg::PAY_W-1:0] r_pay_mem [MAX_ENTRIES];

    kte_pkg::t_op              r_op;
    logic                      r_upd;
    logic [kte_pkg::KEY_W-1:0] r_key;
    logic [kte_pkg::KEY_W-1:0] r_new_key;
    logic [kte_pkg::PAY_W-1:0] r_pay;

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic                      r_dirty;
    logic                      n_dirty;

    logic [CW-1:0]             r_addr;
    logic                      r_scan_act;
    logic                      r_shift_act;
    logic                      r_cmp_vld;
    logic [AW-1:0]             r_cmp_idx;
    logic                      r_wb_vld;
    logic [AW-1:0]             r_wb_addr;
    logic [kte_pkg::KEY_W-1:0] r_rd_key;
    logic [kte_pkg::PAY_W-1:0] r_rd_pay;

    logic                      r_hit_key;
    logic                      r_hit_new;
    logic [AW-1:0]             r_idx;
    logic [kte_pkg::PAY_W-1:0] r_found;

    logic                      r_out_vld;
    kte_pkg::t_status          r_out_status;
    logic [kte_pkg::PAY_W-1:0] r_out_found;
    logic [kte_pkg::USED_W-1:0] r_out_used;
    logic                      r_out_dirty;

    logic                      w_addr_lt;
    logic                      w_rd_en;
    logic                      w_key_we;
    logic [AW-1:0]             w_key_wa;
    logic [kte_pkg::KEY_W-1:0] w_key_wd;
    logic                      w_pay_we;
    logic [AW-1:0]             w_pay_wa;
    logic [kte_pkg::PAY_W-1:0] w_pay_wd;
    logic [CW+kte_pkg::USED_W-1:0] w_cnt_ext;
    logic                      w_out_free;

    assign w_addr_lt  = r_addr < r_count;
    assign w_rd_en    = (r_scan_act || r_shift_act) && w_addr_lt;
    assign w_out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= kte_pkg::t_op'(i_in_user[2:0]);
            r_key     <= i_in_data[63:0];
            r_new_key <= i_in_data[127:64];
            r_pay     <= i_in_data[191:128];
            r_upd     <= i_in_data[192];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_clr) begin
            n_count = '0;
        end else if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CW'(1);
        end
        n_dirty = r_dirty;
        if (i_cmd.dirty_clr) begin
            n_dirty = 1'b0;
        end else if (i_cmd.dirty_set) begin
            n_dirty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dirty <= 1'b0;
        end else begin
            r_count <= n_count;
            r_dirty <= n_dirty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_act  <= 1'b0;
            r_shift_act <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_wb_vld    <= 1'b0;
            r_addr      <= '0;
        end else if (i_cmd.scan_start) begin
            r_scan_act <= 1'b1;
            r_cmp_vld  <= 1'b0;
            r_addr     <= '0;
        end else if (i_cmd.shift_start) begin
            r_shift_act <= 1'b1;
            r_wb_vld    <= 1'b0;
            r_addr      <= CW'(r_idx) + CW'(1);
        end else begin
            r_cmp_vld <= r_scan_act && w_addr_lt;
            r_wb_vld  <= r_shift_act && w_addr_lt;
            if (r_scan_act && !w_addr_lt) begin
                r_scan_act <= 1'b0;
            end
            if (r_shift_act && !w_addr_lt) begin
                r_shift_act <= 1'b0;
            end
            if (w_rd_en) begin
                r_addr <= r_addr + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_key  <= r_key_mem[r_addr[AW-1:0]];
            r_rd_pay  <= r_pay_mem[r_addr[AW-1:0]];
            r_cmp_idx <= r_addr[AW-1:0];
            r_wb_addr <= r_addr[AW-1:0] - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_hit_key <= 1'b0;
            r_hit_new <= 1'b0;
        end else if (r_cmp_vld) begin
            if (r_rd_key == r_key && !r_hit_key) begin
                r_hit_key <= 1'b1;
                r_idx     <= r_cmp_idx;
                r_found   <= r_rd_pay;
            end
            if (r_rd_key == r_new_key) begin
                r_hit_new <= 1'b1;
            end
        end
    end

    always_comb begin
        w_key_we = 1'b0;
        w_key_wa = r_wb_addr;
        w_key_wd = r_rd_key;
        w_pay_we = 1'b0;
        w_pay_wa = r_wb_addr;
        w_pay_wd = r_rd_pay;
        if (r_wb_vld) begin
            w_key_we = 1'b1;
            w_pay_we = 1'b1;
        end else if (i_cmd.wr_add_new) begin
            w_key_we = 1'b1;
            w_key_wa = r_count[AW-1:0];
            w_key_wd = r_key;
            w_pay_we = 1'b1;
            w_pay_wa = r_count[AW-1:0];
            w_pay_wd = r_pay;
        end else if (i_cmd.wr_upd_pay) begin
            w_pay_we = 1'b1;
            w_pay_wa = r_idx;
            w_pay_wd = r_pay;
        end else if (i_cmd.wr_move_key) begin
            w_key_we = 1'b1;
            w_key_wa = r_idx;
            w_key_wd = r_new_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_key_mem[w_key_wa] <= w_key_wd;
        end
        if (w_pay_we) begin
            r_pay_mem[w_pay_wa] <= w_pay_wd;
        end
    end

    assign w_cnt_ext = {{kte_pkg::USED_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.resp_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp_load) begin
            r_out_status <= i_cmd.resp_status;
            r_out_found  <= i_cmd.resp_found ? r_found : '0;
            r_out_used   <= w_cnt_ext[kte_pkg::USED_W-1:0];
            r_out_dirty  <= n_dirty;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = {5'b0, r_out_dirty, r_out_used, r_out_found, r_out_status};

    always_comb begin
        o_sts.op         = r_op;
        o_sts.upd        = r_upd;
        o_sts.hit_key    = r_hit_key;
        o_sts.hit_new    = r_hit_new;
        o_sts.keys_eq    = r_key == r_new_key;
        o_sts.full       = r_count == CntMax;
        o_sts.scan_done  = !r_scan_act && !r_cmp_vld;
        o_sts.shift_done = !r_shift_act && !r_wb_vld;
        o_sts.out_free   = w_out_free;
    end

endmodule

/* rtl/core/keyed_entry_table.sv */
// Lookup, add and move scan the stored entries; remove of a found entry scans and then
// shifts the entries after it down; clear and unused codes skip the scan.
// The single read port of the key and payload memories scans one entry per cycle.
// Throughput: one transaction at a time; a new one is taken while the last result waits.
// Reset clears the entry count, the modified mark and the result valid and returns the
// controller to idle; the stores are not cleared and hold no entry until written.
module keyed_entry_table #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // entry_key, new_key, entry_payload, allow_update, zero fill
    input  logic [kte_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // operation
    input  logic [kte_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // status, found_payload, used_entries, changed_flag, zero fill
    output logic [kte_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    kte_pkg::t_dp_cmd w_cmd;
    kte_pkg::t_dp_sts w_sts;

    kte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_op    (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    kte_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

/* rtl/core/kte_checker.sv */
module kte_checker #(
    parameter int MAX_ENTRIES = 64
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [kte_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam logic [6:0] MaxUsed = 7'(MAX_ENTRIES % 128);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2:0] == kte_pkg::ST_FULL
        |-> o_m_axis_tdata[73:67] == MaxUsed)
        else $error("full status with table not full");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2:0] != kte_pkg::ST_DONE
        |-> o_m_axis_tdata[66:3] == '0)
        else $error("payload reported on a failed transaction");

    a_clean_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[74] |-> o_m_axis_tdata[73:67] == '0)
        else $error("entries held while the modified mark is clear");

endmodule

bind keyed_entry_table kte_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_kte_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int TBL_DEPTH = 64;
    localparam int ITEM_TARGET = 1250;
    localparam int KEY_POOL_N = 96;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE_CYCLES = 2 * TBL_DEPTH + 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST = 3'd7;
    localparam logic [63:0] KEY_LO = 64'h0;
    localparam logic [63:0] KEY_HI = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] found;
        logic [6:0]  used;
        logic        changed;
    } t_resp;

    class table_shadow;
        logic [63:0] key_mem [TBL_DEPTH];
        logic [63:0] pay_mem [TBL_DEPTH];
        int          count;
        bit          dirty;
        t_resp       resp_q[$];
        int          mismatches;
        int          checked;
        int          peak_fill;
        int          op_seen [8];
        int          status_seen [8];

        function new();
            count = 0;
            dirty = 1'b0;
            mismatches = 0;
            checked = 0;
            peak_fill = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int find(logic [63:0] key);
            for (int i = 0; i < count; i++) begin
                if (key_mem[i] == key) return i;
            end
            return count;
        endfunction

        function void note_request(logic [2:0] op, logic [63:0] key, logic [63:0] nkey,
                                   logic [63:0] pay, logic upd);
            t_resp r;
            int    idx;
            r = '0;
            r.status = kte_pkg::ST_DONE;
            case (op)
                kte_pkg::OP_LOOKUP: begin
                    idx = find(key);
                    if (idx < count) r.found = pay_mem[idx];
                    else r.status = kte_pkg::ST_NOT_FOUND;
                end
                kte_pkg::OP_ADD: begin
                    idx = find(key);
                    if (idx < count) begin
                        if (!upd) begin
                            r.status = kte_pkg::ST_EXISTS;
                        end else begin
                            pay_mem[idx] = pay;
                            dirty = 1'b1;
                        end
                    end else if (count >= TBL_DEPTH) begin
                        r.status = kte_pkg::ST_FULL;
                    end else begin
                        key_mem[count] = key;
                        pay_mem[count] = pay;
                        count++;
                        dirty = 1'b1;
                    end
                end
                kte_pkg::OP_REMOVE: begin
                    idx = find(key);
                    if (idx >= count) begin
                        r.status = kte_pkg::ST_NOT_FOUND;
                    end else begin
                        for (int i = idx; i + 1 < count; i++) begin
                            key_mem[i] = key_mem[i + 1];
                            pay_mem[i] = pay_mem[i + 1];
                        end
                        count--;
                        dirty = 1'b1;
                    end
                end
                kte_pkg::OP_MOVE: begin
                    if (key == nkey || find(nkey) < count) begin
                        r.status = kte_pkg::ST_REFUSED;
                    end else begin
                        idx = find(key);
                        if (idx >= count) begin
                            r.status = kte_pkg::ST_NOT_FOUND;
                        end else begin
                            key_mem[idx] = nkey;
                            dirty = 1'b1;
                        end
                    end
                end
                kte_pkg::OP_CLEAR: begin
                    count = 0;
                    dirty = 1'b0;
                end
                default: begin
                end
            endcase
            r.used = count[6:0];
            r.changed = dirty;
            if (count > peak_fill) peak_fill = count;
            op_seen[op]++;
            status_seen[r.status]++;
            resp_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("ERROR at %0t ns: %s", $time, what);
        endtask

        task check_response(logic [kte_pkg::OUT_DATA_W-1:0] d);
            t_resp want;
            if (resp_q.size() == 0) begin
                report_mismatch($sformatf("result 0x%h arrived with nothing pending", d));
                return;
            end
            want = resp_q.pop_front();
            checked++;
            if (d[2:0] !== want.status)
                report_mismatch($sformatf("result %0d status %0d, want %0d",
                                          checked, d[2:0], want.status));
            if (d[66:3] !== want.found)
                report_mismatch($sformatf("result %0d payload 0x%h, want 0x%h",
                                          checked, d[66:3], want.found));
            if (d[73:67] !== want.used)
                report_mismatch($sformatf("result %0d used %0d, want %0d",
                                          checked, d[73:67], want.used));
            if (d[74] !== want.changed)
                report_mismatch($sformatf("result %0d changed %b, want %b",
                                          checked, d[74], want.changed));
            if (d[79:75] !== 5'b0)
                report_mismatch($sformatf("result %0d fill bits %b", checked, d[79:75]));
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    logic [kte_pkg::IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [kte_pkg::IN_USER_W-1:0]  i_s_axis_tuser;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    logic [kte_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;

    table_shadow sb = new();
    logic [63:0] key_pool [KEY_POOL_N];
    int          burst_left = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          hold_req = 1'b0;

    keyed_entry_table #(
        .MAX_ENTRIES(TBL_DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_response(o_m_axis_tdata);
        end
    end

    initial begin : receiver
        int          pat_pos;
        int          hold_left;
        logic [15:0] stall_pattern;
        i_m_axis_tready = 1'b0;
        pat_pos = 0;
        hold_left = 0;
        stall_pattern = '1;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready = 1'b0;
            end else begin
                if (pat_pos == 0) begin
                    case ($urandom_range(0, 2))
                        0: stall_pattern = '1;
                        1: stall_pattern = 16'($urandom);
                        default: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
                    endcase
                end
                i_m_axis_tready = stall_pattern[pat_pos % 16];
                pat_pos = (pat_pos + 1) % 64;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Cycle limit reached with %0d results outstanding.", sb.resp_q.size());
        $display("keyed_entry_table: mismatch");
        $finish;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (sb.count > 0 && r < 50) return sb.key_mem[$urandom_range(0, sb.count - 1)];
        if (r < 88) return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
        return rand_word();
    endfunction

    function automatic logic [63:0] pick_payload();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return KEY_LO;
        if (r == 1) return KEY_HI;
        return rand_word();
    endfunction

    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return kte_pkg::OP_LOOKUP;
        if (r < 55) return kte_pkg::OP_ADD;
        if (r < 72) return kte_pkg::OP_REMOVE;
        if (r < 94) return kte_pkg::OP_MOVE;
        if (r < 96) return kte_pkg::OP_CLEAR;
        return 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    endfunction

    task automatic send_request(logic [2:0] op, logic [63:0] key, logic [63:0] nkey,
                                logic [63:0] pay, logic upd);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tdata = {7'b0, upd, pay, nkey, key};
        i_s_axis_tuser = op;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(op, key, nkey, pay, upd);
        items_sent++;
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (sb.resp_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic mixed_burst(int n);
        logic [63:0] k;
        logic [63:0] nk;
        repeat (n) begin
            k = pick_key();
            nk = ($urandom_range(0, 19) == 0) ? k : pick_key();
            send_request(pick_op(), k, nk, pick_payload(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic fill_and_probe();
        while (sb.count < TBL_DEPTH) begin
            send_request(kte_pkg::OP_ADD, rand_word(), rand_word(), pick_payload(),
                         1'($urandom_range(0, 1)));
        end
        repeat (4) begin
            send_request(kte_pkg::OP_ADD, rand_word(), rand_word(), pick_payload(),
                         1'($urandom_range(0, 1)));
        end
        mixed_burst(8);
        if (sb.count > 0) begin
            send_request(kte_pkg::OP_LOOKUP, sb.key_mem[sb.count - 1], rand_word(),
                         rand_word(), 1'b0);
            send_request(kte_pkg::OP_REMOVE, sb.key_mem[0], rand_word(), rand_word(), 1'b1);
        end
        if ($urandom_range(0, 1) == 1) begin
            send_request(kte_pkg::OP_CLEAR, pick_key(), rand_word(), rand_word(),
                         1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int phase_pick;
        bit hold_done;
        int spare_n;
        hold_done = 1'b0;
        spare_n = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        foreach (key_pool[i]) key_pool[i] = rand_word();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(kte_pkg::OP_LOOKUP, KEY_LO, rand_word(), rand_word(), 1'b0);
        send_request(kte_pkg::OP_REMOVE, KEY_HI, rand_word(), rand_word(), 1'b1);
        send_request(kte_pkg::OP_MOVE, KEY_LO, KEY_HI, rand_word(), 1'b0);
        send_request(kte_pkg::OP_ADD, KEY_LO, rand_word(), KEY_HI, 1'b0);
        send_request(kte_pkg::OP_ADD, KEY_HI, rand_word(), KEY_LO, 1'b1);
        send_request(kte_pkg::OP_LOOKUP, KEY_LO, KEY_HI, rand_word(), 1'b1);
        send_request(kte_pkg::OP_LOOKUP, KEY_HI, KEY_LO, rand_word(), 1'b0);
        send_request(kte_pkg::OP_ADD, KEY_LO, rand_word(), KEY_LO, 1'b0);
        send_request(kte_pkg::OP_ADD, KEY_LO, rand_word(), KEY_HI, 1'b1);
        send_request(kte_pkg::OP_MOVE, KEY_LO, KEY_LO, rand_word(), 1'b0);
        send_request(kte_pkg::OP_MOVE, KEY_LO, KEY_HI, rand_word(), 1'b1);
        send_request(kte_pkg::OP_MOVE, key_pool[2], KEY_HI, rand_word(), 1'b0);
        send_request(kte_pkg::OP_MOVE, KEY_LO, key_pool[2], rand_word(), 1'b0);
        send_request(kte_pkg::OP_LOOKUP, key_pool[2], rand_word(), rand_word(), 1'b0);
        send_request(kte_pkg::OP_ADD, key_pool[3], rand_word(), rand_word(), 1'b0);
        send_request(kte_pkg::OP_REMOVE, key_pool[2], rand_word(), rand_word(), 1'b0);
        send_request(kte_pkg::OP_REMOVE, key_pool[3], rand_word(), rand_word(), 1'b1);
        send_request(kte_pkg::OP_LOOKUP, KEY_HI, rand_word(), rand_word(), 1'b0);
        send_request(kte_pkg::OP_CLEAR, rand_word(), rand_word(), rand_word(), 1'b1);
        send_request(kte_pkg::OP_LOOKUP, KEY_HI, rand_word(), rand_word(), 1'b0);
        for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
            send_request(3'(c), rand_word(), rand_word(), rand_word(), 1'($urandom_range(0, 1)));
        end
        wait_all_results();

        while (items_sent < ITEM_TARGET) begin
            if (!hold_done && items_sent >= 400) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
                mixed_burst(12);
            end
            phase_pick = $urandom_range(0, 11);
            if (phase_pick < 9) mixed_burst($urandom_range(10, 60));
            else if (phase_pick < 11) fill_and_probe();
            else wait_all_results();
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
            spare_n += sb.op_seen[c];
        end
        $display("Ran %0d requests: %0d lookup, %0d add, %0d remove, %0d move, %0d clear, %0d spare.",
                 items_sent, sb.op_seen[kte_pkg::OP_LOOKUP], sb.op_seen[kte_pkg::OP_ADD],
                 sb.op_seen[kte_pkg::OP_REMOVE], sb.op_seen[kte_pkg::OP_MOVE],
                 sb.op_seen[kte_pkg::OP_CLEAR], spare_n);
        $display("Checked %0d results; %0d full, %0d refused, %0d misses, peak fill %0d.",
                 sb.checked, sb.status_seen[kte_pkg::ST_FULL],
                 sb.status_seen[kte_pkg::ST_REFUSED],
                 sb.status_seen[kte_pkg::ST_NOT_FOUND], sb.peak_fill);
        if (sb.mismatches == 0 && sb.resp_q.size() == 0) begin
            $display("keyed_entry_table: match");
        end else begin
            $display("keyed_entry_table: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/kte_pkg.sv
rtl/core/kte_ctrl.sv
rtl/core/kte_datapath.sv
rtl/core/keyed_entry_table.sv
rtl/core/kte_checker.sv
tb/tb_top.sv
